[design/linear_gradient_pixel_unit_defines.svh]
// Assertion macros used by the checker file lgp_checker.sv.
// Depends on a clock named aclk and an active-low reset named aresetn.
`ifndef LINEAR_GRADIENT_PIXEL_UNIT_DEFINES_SVH
`define LINEAR_GRADIENT_PIXEL_UNIT_DEFINES_SVH

// checked only out of reset
`define LGP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define LGP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/lgp_pkg.sv]
// Shared types and constants for the linear gradient pixel unit.
// No dependencies.
`timescale 1ns / 1ps

package lgp_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;

    localparam int COORD_W = 16;          // Q12.4 endpoint coordinate
    localparam int PIX_W   = 12;          // pixel index
    localparam int Q4_W    = PIX_W + 4;   // pixel index in Q12.4, unsigned
    localparam int DIFF_W  = COORD_W + 1; // end - start
    localparam int PROJ_W  = 36;          // projections c, c1, c2
    localparam int SPAN_W  = 34;          // c2 - c1 = a*a + b*b
    localparam int NUM_W   = SPAN_W + 10; // 2*num + span
    localparam int DEN_W   = SPAN_W + 1;  // 2*span
    localparam int CHAN    = 4;
    localparam int QBITS   = 8;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    typedef enum logic [CFG_AW-1:0] {
        REG_START_X     = 3'd0,
        REG_START_Y     = 3'd1,
        REG_END_X       = 3'd2,
        REG_END_Y       = 3'd3,
        REG_COLOR_START = 3'd4,
        REG_COLOR_END   = 3'd5,
        REG_ALPHA_EN    = 3'd6
    } lgp_reg_t;

    // one beat flowing through the divider cells
    typedef struct packed {
        logic [CHAN-1:0][NUM_W-1:0] rem;
        logic [CHAN-1:0][QBITS-1:0] quo;
        logic [DEN_W-1:0]           den;
        logic                       below;
        logic                       above;
    } lgp_div_t;

    // channel k of a packed RGBA word, red first
    function automatic logic [7:0] chan_of(input logic [31:0] col, input int k);
        logic [7:0] r;
        r = col[8*(3-k) +: 8];
        return r;
    endfunction

endpackage

[design/lgp_front.sv]
// Projection front end: endpoint differences, projections, weights, numerators.
// Five pipeline stages with per-stage flow control. Uses lgp_pkg.
`timescale 1ns / 1ps

module lgp_front
    import lgp_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PIX_W-1:0]          pixel_x,
    input  logic [PIX_W-1:0]          pixel_y,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    input  logic [31:0]               color_start,
    input  logic [31:0]               color_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lgp_div_t                  out_data
);

    localparam logic [Q4_W:0] LIM = (Q4_W+1)'(MAX_DIMENSION - 1);

    logic [5:1] v_reg;
    logic [5:1] ld;

    assign ld[5] = !v_reg[5] || out_ready;
    assign ld[4] = !v_reg[4] || ld[5];
    assign ld[3] = !v_reg[3] || ld[4];
    assign ld[2] = !v_reg[2] || ld[3];
    assign ld[1] = !v_reg[1] || ld[2];
    assign in_ready = ld[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[1]) v_reg[1] <= in_valid;
            if (ld[2]) v_reg[2] <= v_reg[1];
            if (ld[3]) v_reg[3] <= v_reg[2];
            if (ld[4]) v_reg[4] <= v_reg[3];
            if (ld[5]) v_reg[5] <= v_reg[4];
        end
    end

    // stage 1: direction and clamped pixel position
    logic signed [DIFF_W-1:0] a_reg, b_reg, a_next, b_next;
    logic [Q4_W:0]            px_reg, py_reg, px_next, py_next;
    logic [Q4_W:0]            xe, ye;

    always_comb begin
        a_next = $signed({end_x[COORD_W-1], end_x}) - $signed({start_x[COORD_W-1], start_x});
        b_next = $signed({end_y[COORD_W-1], end_y}) - $signed({start_y[COORD_W-1], start_y});
        xe = (Q4_W+1)'(pixel_x);
        ye = (Q4_W+1)'(pixel_y);
        if (xe > LIM) xe = LIM;
        if (ye > LIM) ye = LIM;
        px_next = {xe[Q4_W-4:0], 4'b0};
        py_next = {ye[Q4_W-4:0], 4'b0};
    end

    // stage 2: products
    logic signed [DIFF_W+Q4_W:0]      pa_reg, pb_reg, pa_next, pb_next;
    logic signed [DIFF_W+COORD_W-1:0] s1a_reg, s1b_reg, s2a_reg, s2b_reg;
    logic signed [DIFF_W+COORD_W-1:0] s1a_next, s1b_next, s2a_next, s2b_next;

    always_comb begin
        pa_next  = a_reg * $signed(px_reg);
        pb_next  = b_reg * $signed(py_reg);
        s1a_next = a_reg * start_x;
        s1b_next = b_reg * start_y;
        s2a_next = a_reg * end_x;
        s2b_next = b_reg * end_y;
    end

    // stage 3: projections
    logic signed [PROJ_W-1:0] c_reg, c1_reg, c2_reg, c_next, c1_next, c2_next;

    always_comb begin
        c_next  = PROJ_W'(pa_reg) + PROJ_W'(pb_reg);
        c1_next = PROJ_W'(s1a_reg) + PROJ_W'(s1b_reg);
        c2_next = PROJ_W'(s2a_reg) + PROJ_W'(s2b_reg);
    end

    // stage 4: region and weights
    logic              below_reg, above_reg, below_next, above_next;
    logic [SPAN_W-1:0] w1_reg, w2_reg, dc_reg, w1_next, w2_next, dc_next;
    logic [PROJ_W-1:0] w1_full, w2_full, dc_full;

    always_comb begin
        below_next = c_reg <= c1_reg;
        above_next = c_reg >= c2_reg;
        w1_full = c2_reg - c_reg;
        w2_full = c_reg - c1_reg;
        dc_full = c2_reg - c1_reg;
        w1_next = w1_full[SPAN_W-1:0];
        w2_next = w2_full[SPAN_W-1:0];
        dc_next = dc_full[SPAN_W-1:0];
    end

    // stage 5: rounded-division operands, N = 2*num + span, D = 2*span
    lgp_div_t d_reg, d_next;
    logic [NUM_W-2:0] num;

    always_comb begin
        d_next = '0;
        num = '0;
        for (int k = 0; k < CHAN; k++) begin
            num = (NUM_W-1)'(chan_of(color_start, k)) * (NUM_W-1)'(w1_reg)
                + (NUM_W-1)'(chan_of(color_end, k)) * (NUM_W-1)'(w2_reg);
            d_next.rem[k] = {num, 1'b0} + NUM_W'(dc_reg);
        end
        d_next.den   = {dc_reg, 1'b0};
        d_next.below = below_reg;
        d_next.above = above_reg;
    end

    always_ff @(posedge aclk) begin
        if (ld[1] && in_valid) begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (ld[2] && v_reg[1]) begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            s1a_reg <= s1a_next;
            s1b_reg <= s1b_next;
            s2a_reg <= s2a_next;
            s2b_reg <= s2b_next;
        end
        if (ld[3] && v_reg[2]) begin
            c_reg  <= c_next;
            c1_reg <= c1_next;
            c2_reg <= c2_next;
        end
        if (ld[4] && v_reg[3]) begin
            below_reg <= below_next;
            above_reg <= above_next;
            w1_reg    <= w1_next;
            w2_reg    <= w2_next;
            dc_reg    <= dc_next;
        end
        if (ld[5] && v_reg[4]) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg[5];
    assign out_data  = d_reg;

endmodule

[design/lgp_div_cell.sv]
// One restoring-division cell: resolves quotient bit BIT for all four channels.
// Uses lgp_pkg.
`timescale 1ns / 1ps

module lgp_div_cell
    import lgp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  lgp_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lgp_div_t out_data
);

    logic     v_reg;
    lgp_div_t d_reg, d_next;
    logic [NUM_W-1:0] sub;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        d_next = in_data;
        sub = NUM_W'(in_data.den) << BIT;
        for (int k = 0; k < CHAN; k++) begin
            if (in_data.rem[k] >= sub) begin
                d_next.rem[k]      = in_data.rem[k] - sub;
                d_next.quo[k][BIT] = 1'b1;
            end else begin
                d_next.quo[k][BIT] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

[design/linear_gradient_pixel_unit.sv]
// Linear gradient pixel unit: top level with configuration registers, front end,
// divider cell chain and output register. Uses lgp_pkg, lgp_front, lgp_div_cell.
//
// Usage: write the endpoints (Q12.4), the two RGBA colors and alpha_enable through
// the cfg_wr_en / cfg_addr / cfg_wr_data port while no pixel is in flight. Then
// stream pixel coordinates on s_axis (tdata: pixel_x, pixel_y) and take RGBA
// results on m_axis (tdata: red, green, blue, alpha), one result beat per input.
// The pipeline is five projection stages, eight divider cells (one quotient
// bit each) and the output register. Throughput is one pixel per cycle while m_tready
// holds, set by the per-channel 8x34 multiplies and one compare-subtract per cell.
// Each stage holds its own valid bit, so bubbles collapse and the unit keeps taking
// beats while a result waits on m_axis; only when every stage is full does a stall
// on m_tready reach s_tready. Reset empties the pipeline and restores the register
// defaults (start color black, end color white, alpha forced opaque).
`timescale 1ns / 1ps

module linear_gradient_pixel_unit
    import lgp_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,      // pixel_x[11:0], pixel_y[23:12]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,      // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wr_data
);

    logic signed [COORD_W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [31:0]               color_start_reg, color_end_reg;
    logic                      alpha_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            color_start_reg <= '0;
            color_end_reg   <= '1;
            alpha_en_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (lgp_reg_t'(cfg_addr))
                REG_START_X:     start_x_reg     <= cfg_wr_data[COORD_W-1:0];
                REG_START_Y:     start_y_reg     <= cfg_wr_data[COORD_W-1:0];
                REG_END_X:       end_x_reg       <= cfg_wr_data[COORD_W-1:0];
                REG_END_Y:       end_y_reg       <= cfg_wr_data[COORD_W-1:0];
                REG_COLOR_START: color_start_reg <= cfg_wr_data;
                REG_COLOR_END:   color_end_reg   <= cfg_wr_data;
                REG_ALPHA_EN:    alpha_en_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic     [QBITS:0] cv, cr;
    lgp_div_t           cd [QBITS+1];

    lgp_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pixel_x     (s_tdata[PIX_W-1:0]),
        .pixel_y     (s_tdata[2*PIX_W-1:PIX_W]),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .end_x       (end_x_reg),
        .end_y       (end_y_reg),
        .color_start (color_start_reg),
        .color_end   (color_end_reg),
        .out_valid   (cv[0]),
        .out_ready   (cr[0]),
        .out_data    (cd[0])
    );

    // cell j resolves quotient bit QBITS-1-j
    for (genvar j = 0; j < QBITS; j++) begin : g_cell
        lgp_div_cell #(
            .BIT(QBITS - 1 - j)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[j]),
            .in_ready  (cr[j]),
            .in_data   (cd[j]),
            .out_valid (cv[j+1]),
            .out_ready (cr[j+1]),
            .out_data  (cd[j+1])
        );
    end

    logic        m_valid_reg;
    logic [31:0] m_data_reg, m_data_next;
    lgp_div_t    fin;

    assign cr[QBITS] = !m_valid_reg || m_tready;
    assign fin = cd[QBITS];

    always_comb begin
        m_data_next = '0;
        for (int k = 0; k < CHAN; k++) begin
            if (fin.below) begin
                m_data_next[8*k +: 8] = chan_of(color_start_reg, k);
            end else if (fin.above) begin
                m_data_next[8*k +: 8] = chan_of(color_end_reg, k);
            end else begin
                m_data_next[8*k +: 8] = fin.quo[k];
            end
        end
        if (!fin.below && !fin.above && !alpha_en_reg) begin
            m_data_next[31:24] = 8'hFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cr[QBITS]) begin
            m_valid_reg <= cv[QBITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (cr[QBITS] && cv[QBITS]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[design/lgp_checker.sv]
// Port-level checks for linear_gradient_pixel_unit, bound to the top level.
// Uses linear_gradient_pixel_unit_defines.svh.
`timescale 1ns / 1ps
`include "linear_gradient_pixel_unit_defines.svh"

module lgp_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    localparam logic [4:0] DEPTH = 5'd14;

    // beats accepted but not yet delivered
    logic [4:0] cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (s_tvalid && s_tready) cnt_next = cnt_next + 5'd1;
        if (m_tvalid && m_tready) cnt_next = cnt_next - 5'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `LGP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped under stall")
    `LGP_ASSERT(a_no_phantom, m_tvalid |-> cnt_reg != 5'd0, "result beat without an input beat")
    `LGP_ASSERT(a_depth, cnt_reg <= DEPTH, "more beats in flight than pipeline stages")
    `LGP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind linear_gradient_pixel_unit lgp_checker u_lgp_checker (.*);

[bench/gradient_checker.sv]
// Gradient result checker: watches the pixel and color streams, predicts each
// color from its own copy of the registers and compares field by field.
// Depends on lgp_pkg for the register index enum and the port widths.
`timescale 1ns / 1ps

module gradient_checker
    import lgp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wr_data,
    output int                fail_count,
    output int                pending,
    output int                colors_seen
);

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    logic signed [15:0] gx0, gy0, gx1, gy1;
    logic [31:0]        col0, col1;
    logic               alpha_on;
    rgba_t              expected_colors[$];

    function automatic rgba_t shade_pixel(input logic [11:0] px, input logic [11:0] py);
        longint a, b, c, c1, c2, w1, w2, dc, num, q;
        logic [31:0] col;
        rgba_t res;
        logic [7:0] ch[4];
        a  = longint'(gx1) - longint'(gx0);
        b  = longint'(gy1) - longint'(gy0);
        c1 = a * gx0 + b * gy0;
        c2 = a * gx1 + b * gy1;
        c  = a * (longint'(px) * 16) + b * (longint'(py) * 16);
        if (c <= c1 || c >= c2) begin
            col = (c <= c1) ? col0 : col1;
            for (int k = 0; k < 4; k++) ch[k] = col[8*(3-k) +: 8];
        end else begin
            w1 = c2 - c;
            w2 = c - c1;
            dc = c2 - c1;
            for (int k = 0; k < 4; k++) begin
                num = longint'(col0[8*(3-k) +: 8]) * w1 + longint'(col1[8*(3-k) +: 8]) * w2;
                q = (2 * num + dc) / (2 * dc);
                ch[k] = (q > 255) ? 8'd255 : q[7:0];
            end
            if (!alpha_on) ch[3] = 8'd255;
        end
        res.red = ch[0]; res.green = ch[1]; res.blue = ch[2]; res.alpha = ch[3];
        return res;
    endfunction

    always @(posedge aclk) begin
        rgba_t want, got;
        if (!aresetn) begin
            gx0 <= '0; gy0 <= '0; gx1 <= '0; gy1 <= '0;
            col0 <= '0; col1 <= 32'hFFFF_FFFF; alpha_on <= 1'b0;
            expected_colors.delete();
            fail_count <= 0;
            colors_seen <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_START_X:     gx0 <= cfg_wr_data[15:0];
                    REG_START_Y:     gy0 <= cfg_wr_data[15:0];
                    REG_END_X:       gx1 <= cfg_wr_data[15:0];
                    REG_END_Y:       gy1 <= cfg_wr_data[15:0];
                    REG_COLOR_START: col0 <= cfg_wr_data;
                    REG_COLOR_END:   col1 <= cfg_wr_data;
                    REG_ALPHA_EN:    alpha_on <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_colors.push_back(shade_pixel(s_tdata[11:0], s_tdata[23:12]));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                colors_seen <= colors_seen + 1;
                if (expected_colors.size() == 0) begin
                    $error("color beat with no pixel pending: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_colors.pop_front();
                    if (got != want) begin
                        fail_count <= fail_count + 1;
                        if (got.red != want.red)
                            $error("red: expected %0d, got %0d", want.red, got.red);
                        if (got.green != want.green)
                            $error("green: expected %0d, got %0d", want.green, got.green);
                        if (got.blue != want.blue)
                            $error("blue: expected %0d, got %0d", want.blue, got.blue);
                        if (got.alpha != want.alpha)
                            $error("alpha: expected %0d, got %0d", want.alpha, got.alpha);
                    end
                end
            end
        end
        pending <= expected_colors.size();
    end

endmodule

[bench/testbench.sv]
// Top of the gradient unit bench: clock, reset, register writes, pixel stimulus
// with idle phases and backpressure. Uses lgp_pkg, linear_gradient_pixel_unit and gradient_checker.
`timescale 1ns / 1ps

module testbench;
    import lgp_pkg::*;

    localparam int LATENCY = 14;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid, s_tready;
    logic [23:0]       s_tdata;
    logic              m_tvalid, m_tready;
    logic [31:0]       m_tdata;
    logic              cfg_wr_en;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wr_data;
    int                fail_count, pending, colors_seen;
    int                send_idle_pct, recv_stall_pct;
    int                hold_off_cycles;
    int                pixels_sent;

    linear_gradient_pixel_unit u_top (.*);

    gradient_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("** linear_gradient_pixel_unit: FAILED **");
        $finish;
    end

    // receiver: random stall, or a long hold-off when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // driven at the falling edge; back-to-back calls may retoggle the enable
    task automatic write_reg(input lgp_reg_t idx, input logic [31:0] val);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        pixels_sent++;
    endtask

    task automatic drain_pipe();
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic set_gradient(input logic [15:0] x0, input logic [15:0] y0,
                                input logic [15:0] x1, input logic [15:0] y1,
                                input logic [31:0] c0, input logic [31:0] c1,
                                input logic ae);
        write_reg(REG_START_X, {16'h0, x0});
        write_reg(REG_START_Y, {16'h0, y0});
        write_reg(REG_END_X, {16'h0, x1});
        write_reg(REG_END_Y, {16'h0, y1});
        write_reg(REG_COLOR_START, c0);
        write_reg(REG_COLOR_END, c1);
        write_reg(REG_ALPHA_EN, {31'h0, ae});
    endtask

    // random pixel, mostly within 0..span on each axis, sometimes anywhere
    function automatic logic [23:0] pick_pixel(input int span);
        logic [11:0] px, py;
        if ($urandom_range(3) == 0) begin
            px = 12'($urandom); py = 12'($urandom);
        end else begin
            px = 12'($urandom_range(span)); py = 12'($urandom_range(span));
        end
        return {py, px};
    endfunction

    initial begin
        logic [23:0] p;
        int span;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wr_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
        pixels_sent = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: start equals end, every pixel gets the start color
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        drain_pipe();

        // horizontal band 0..64 pixels, alpha forced opaque inside
        set_gradient(16'd0, 16'd0, 16'd1024, 16'd0, 32'h10_20_30_40, 32'hF0_E0_D0_05, 1'b0);
        send_pixel(12'd0, 12'd5);       // on the start boundary
        send_pixel(12'd64, 12'd7);      // on the end boundary
        send_pixel(12'd32, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd63, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        drain_pipe();
        write_reg(REG_ALPHA_EN, 32'h1);
        send_pixel(12'd32, 12'd9);
        send_pixel(12'd17, 12'd0);
        drain_pipe();

        // extreme endpoints, reversed direction, full swing colors
        set_gradient(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 32'h0, 1'b1);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'h800, 12'h800);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain_pipe();
        write_reg(lgp_reg_t'(3'd7), 32'hDEAD_BEEF);  // unmapped index, ignored
        send_pixel(12'd100, 12'd200);
        drain_pipe();

        // random phases: settings change only with the pipe empty
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 11)
                set_gradient(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                             32'h0, 32'hFFFF_FFFF, 1'b0);
            else begin
                logic [15:0] x0, y0;
                x0 = 16'($urandom_range(16'h1000)); y0 = 16'($urandom_range(16'h1000));
                set_gradient(x0, y0, 16'(x0 + $urandom_range(4096) - 1024),
                             16'(y0 + $urandom_range(4096) - 1024),
                             $urandom, $urandom, ph[0]);
            end
            span = (ph % 3 == 0) ? 4095 : 400;
            for (int i = 0; i < 90; i++) begin
                if (ph == 2 && i == 20) hold_off_cycles = 60;
                if (ph == 5 && i == 45) drain_pipe();
                p = pick_pixel(span);
                send_pixel(p[11:0], p[23:12]);
            end
            drain_pipe();
        end

        $display("Run covered %0d pixels and %0d colors over reset defaults,", pixels_sent,
                 colors_seen);
        $display("extreme endpoints, both alpha modes, idle phases and a long output hold-off.");
        if (fail_count == 0)
            $display("** linear_gradient_pixel_unit: PASSED **");
        else
            $display("** linear_gradient_pixel_unit: FAILED **");
        $finish;
    end

endmodule
